// ----- rtl/core/hsl_to_rgb_converter_unit_macros.svh -----
// Assertion macros shared by the front and mix stages of the HSL to RGB converter.
`ifndef HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`define HSL_TO_RGB_CONVERTER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HSL_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed: %m");
`define HSL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
`define HSL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define HSL_ASSERT_ALWAYS(label, clk, rstn, expr)
`define HSL_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define HSL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ----- rtl/core/hsl2rgb_pkg.sv -----
// Types, constants and helper functions of the HSL to RGB converter.
`default_nettype none
package hsl2rgb_pkg;

    localparam int unsigned HUE_FULL    = 360;
    localparam int unsigned PCT_FULL    = 100;
    localparam int unsigned SECTOR_DEG  = 60;
    localparam int unsigned HALF_SECTOR = 30;
    localparam int unsigned LIGHT_UNIT  = 6000;
    localparam int unsigned DENOM       = 600000;

    // (v * 255 + 300000) / 600000 == ((v * 17 + 20000) >> 6) / 625
    localparam int unsigned SCALE_MUL   = 17;
    localparam int unsigned ROUND_OFS   = 20000;
    localparam int unsigned PRE_SHIFT   = 6;
    localparam int unsigned PRE_MAX     = 159687;
    // ceil(2^28 / 625), exact for every pre-scaled value up to PRE_MAX
    localparam int unsigned RECIP_M     = 429497;
    localparam int unsigned RECIP_SHIFT = 28;

    typedef enum logic [2:0] {
        SEC_R_Y = 3'd0,
        SEC_Y_G = 3'd1,
        SEC_G_C = 3'd2,
        SEC_C_B = 3'd3,
        SEC_B_M = 3'd4,
        SEC_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        sector_t     sector;
        logic [5:0]  hd;
        logic [13:0] cn;
        logic [6:0]  light;
    } front_t;

    typedef struct packed {
        logic [17:0] z_r;
        logic [17:0] z_g;
        logic [17:0] z_b;
    } chan_t;

    function automatic logic [17:0] pre_scale(input logic [19:0] v);
        logic [23:0] y;
        y = 24'(v) * 24'(SCALE_MUL) + 24'(ROUND_OFS);
        return 18'(y >> PRE_SHIFT);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/hsl2rgb_front.sv -----
// Input conditioning, hue sector split and chroma product (two stages).
`default_nettype none
`include "hsl_to_rgb_converter_unit_macros.svh"
module hsl2rgb_front import hsl2rgb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [8:0] hue_deg,
    input  logic [6:0] sat_pct,
    input  logic [6:0] light_pct,
    output logic       out_valid,
    input  logic       out_ready,
    output front_t     out_data
);

    logic       v1_reg;
    logic [8:0] h1_reg;
    logic [8:0] h1_next;
    logic [6:0] s1_reg;
    logic [6:0] s1_next;
    logic [6:0] l1_reg;
    logic [6:0] l1_next;
    logic       v2_reg;
    front_t     d2_reg;
    front_t     d2_next;
    logic       ready1;
    logic       ready2;

    logic [8:0] hm_full;
    logic [6:0] hm;
    logic [7:0] twol;
    logic [7:0] l_off;
    logic [6:0] span;

    assign ready2    = !v2_reg || out_ready;
    assign ready1    = !v1_reg || ready2;
    assign in_ready  = ready1;
    assign out_valid = v2_reg;
    assign out_data  = d2_reg;

    // wrap hue, clamp percentages
    always_comb begin
        h1_next = (hue_deg >= 9'(HUE_FULL)) ? hue_deg - 9'(HUE_FULL) : hue_deg;
        s1_next = (sat_pct > 7'(PCT_FULL)) ? 7'(PCT_FULL) : sat_pct;
        l1_next = (light_pct > 7'(PCT_FULL)) ? 7'(PCT_FULL) : light_pct;
    end

    always_comb begin
        if (h1_reg < 9'(SECTOR_DEG)) begin
            d2_next.sector = SEC_R_Y;
            hm_full        = h1_reg;
        end else if (h1_reg < 9'(2 * SECTOR_DEG)) begin
            d2_next.sector = SEC_Y_G;
            hm_full        = h1_reg;
        end else if (h1_reg < 9'(3 * SECTOR_DEG)) begin
            d2_next.sector = SEC_G_C;
            hm_full        = h1_reg - 9'(2 * SECTOR_DEG);
        end else if (h1_reg < 9'(4 * SECTOR_DEG)) begin
            d2_next.sector = SEC_C_B;
            hm_full        = h1_reg - 9'(2 * SECTOR_DEG);
        end else if (h1_reg < 9'(5 * SECTOR_DEG)) begin
            d2_next.sector = SEC_B_M;
            hm_full        = h1_reg - 9'(4 * SECTOR_DEG);
        end else begin
            d2_next.sector = SEC_M_R;
            hm_full        = h1_reg - 9'(4 * SECTOR_DEG);
        end
        hm         = hm_full[6:0];
        d2_next.hd = (hm >= 7'(SECTOR_DEG)) ? 6'(hm - 7'(SECTOR_DEG))
                                            : 6'(7'(SECTOR_DEG) - hm);
        twol       = {l1_reg, 1'b0};
        l_off      = (twol >= 8'(PCT_FULL)) ? twol - 8'(PCT_FULL) : 8'(PCT_FULL) - twol;
        span       = 7'(PCT_FULL) - l_off[6:0];
        d2_next.cn = 14'(span) * 14'(s1_reg);
        d2_next.light = l1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (ready1) begin
                v1_reg <= in_valid;
            end
            if (ready2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1 && in_valid) begin
            h1_reg <= h1_next;
            s1_reg <= s1_next;
            l1_reg <= l1_next;
        end
        if (ready2 && v1_reg) begin
            d2_reg <= d2_next;
        end
    end

    `HSL_ASSERT_IMPL(a_hue_wrapped, aclk, aresetn, v1_reg, h1_reg < 9'(HUE_FULL))
    `HSL_ASSERT_IMPL(a_pct_clamped, aclk, aresetn, v1_reg,
        (s1_reg <= 7'(PCT_FULL)) && (l1_reg <= 7'(PCT_FULL)))
    `HSL_ASSERT_IMPL(a_front_range, aclk, aresetn, v2_reg,
        (d2_reg.cn <= 14'(PCT_FULL * PCT_FULL)) && (d2_reg.hd <= 6'(SECTOR_DEG)))

endmodule
`default_nettype wire

// ----- rtl/core/hsl2rgb_mix.sv -----
// Component products, channel placement and pre-scaling (two stages).
`default_nettype none
`include "hsl_to_rgb_converter_unit_macros.svh"
module hsl2rgb_mix import hsl2rgb_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output chan_t  out_data
);

    logic        v3_reg;
    sector_t     sec3_reg;
    logic [19:0] cu_reg;
    logic [19:0] cu_next;
    logic [19:0] xu_reg;
    logic [19:0] xu_next;
    logic [19:0] mu_reg;
    logic [19:0] mu_next;
    logic        v4_reg;
    chan_t       z_reg;
    chan_t       z_next;
    logic        ready3;
    logic        ready4;
    logic [19:0] comp_r;
    logic [19:0] comp_g;
    logic [19:0] comp_b;

    assign ready4    = !v4_reg || out_ready;
    assign ready3    = !v3_reg || ready4;
    assign in_ready  = ready3;
    assign out_valid = v4_reg;
    assign out_data  = z_reg;

    always_comb begin
        cu_next = 20'(in_data.cn) * 20'(SECTOR_DEG);
        xu_next = 20'(in_data.cn) * (20'(SECTOR_DEG) - 20'(in_data.hd));
        mu_next = 20'(in_data.light) * 20'(LIGHT_UNIT)
                - 20'(in_data.cn) * 20'(HALF_SECTOR);
    end

    always_comb begin
        case (sec3_reg)
            SEC_R_Y: begin
                comp_r = cu_reg; comp_g = xu_reg; comp_b = '0;
            end
            SEC_Y_G: begin
                comp_r = xu_reg; comp_g = cu_reg; comp_b = '0;
            end
            SEC_G_C: begin
                comp_r = '0; comp_g = cu_reg; comp_b = xu_reg;
            end
            SEC_C_B: begin
                comp_r = '0; comp_g = xu_reg; comp_b = cu_reg;
            end
            SEC_B_M: begin
                comp_r = xu_reg; comp_g = '0; comp_b = cu_reg;
            end
            default: begin
                comp_r = cu_reg; comp_g = '0; comp_b = xu_reg;
            end
        endcase
        z_next.z_r = pre_scale(comp_r + mu_reg);
        z_next.z_g = pre_scale(comp_g + mu_reg);
        z_next.z_b = pre_scale(comp_b + mu_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ready3) begin
                v3_reg <= in_valid;
            end
            if (ready4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ready3 && in_valid) begin
            sec3_reg <= in_data.sector;
            cu_reg   <= cu_next;
            xu_reg   <= xu_next;
            mu_reg   <= mu_next;
        end
        if (ready4 && v3_reg) begin
            z_reg <= z_next;
        end
    end

    `HSL_ASSERT_IMPL(a_level_bound, aclk, aresetn, v3_reg,
        ({1'b0, cu_reg} + {1'b0, mu_reg}) <= 21'(DENOM))
    `HSL_ASSERT_IMPL(a_second_le_chroma, aclk, aresetn, v3_reg, xu_reg <= cu_reg)
    `HSL_ASSERT_NEXT(a_stall_hold, aclk, aresetn, v4_reg && !out_ready,
        v4_reg && $stable(z_reg))
    `HSL_ASSERT_IMPL(a_prescale_range, aclk, aresetn, v4_reg,
        (z_reg.z_r <= 18'(PRE_MAX)) && (z_reg.z_g <= 18'(PRE_MAX))
        && (z_reg.z_b <= 18'(PRE_MAX)))

endmodule
`default_nettype wire

// ----- rtl/core/hsl2rgb_scale.sv -----
// Final division by 625 through a reciprocal product, into the output register.
`default_nettype none
module hsl2rgb_scale import hsl2rgb_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  chan_t      in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] red,
    output logic [7:0] green,
    output logic [7:0] blue
);

    logic        v_reg;
    logic [7:0]  r_reg;
    logic [7:0]  r_next;
    logic [7:0]  g_reg;
    logic [7:0]  g_next;
    logic [7:0]  b_reg;
    logic [7:0]  b_next;
    logic        ready;
    logic [36:0] pr;
    logic [36:0] pg;
    logic [36:0] pb;

    assign ready     = !v_reg || out_ready;
    assign in_ready  = ready;
    assign out_valid = v_reg;
    assign red       = r_reg;
    assign green     = g_reg;
    assign blue      = b_reg;

    always_comb begin
        pr     = 37'(in_data.z_r) * 37'(RECIP_M);
        pg     = 37'(in_data.z_g) * 37'(RECIP_M);
        pb     = 37'(in_data.z_b) * 37'(RECIP_M);
        r_next = 8'(pr >> RECIP_SHIFT);
        g_next = 8'(pg >> RECIP_SHIFT);
        b_next = 8'(pb >> RECIP_SHIFT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready && in_valid) begin
            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/hsl_to_rgb_converter_unit.sv -----
// Top level of the HSL to RGB converter.
// Converts one HSL color per request into 8-bit RGB, rounded half up. The datapath is a
// five-stage pipeline (input conditioning, sector and chroma, component products, channel
// placement, reciprocal scaling) that takes one request every clock unless it is full
// behind a stalled output; each request is registered through the stages in that order.
// Each stage holds its own valid bit and advances when the stage after it is empty or
// moving, so a stalled output still lets requests fill the bubbles behind it. Hues of
// 360 and above wrap, percentages above 100 clamp to 100.
`default_nettype none
module hsl_to_rgb_converter_unit import hsl2rgb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // hue_deg[8:0], sat_pct[15:9], light_pct[22:16], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    logic   front_valid;
    logic   front_ready;
    front_t front_data;
    logic   mix_valid;
    logic   mix_ready;
    chan_t  mix_data;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    hsl2rgb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .hue_deg   (s_tdata[8:0]),
        .sat_pct   (s_tdata[15:9]),
        .light_pct (s_tdata[22:16]),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    hsl2rgb_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mix_valid),
        .out_ready (mix_ready),
        .out_data  (mix_data)
    );

    hsl2rgb_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mix_valid),
        .in_ready  (mix_ready),
        .in_data   (mix_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule
`default_nettype wire

// ----- test/tb_hsl_to_rgb_converter_unit.sv -----
`timescale 1ns / 100ps
// Testbench for the HSL to RGB converter: predicted colors checked over a stalling stream.
module tb_hsl_to_rgb_converter_unit import hsl2rgb_pkg::*;;

    typedef struct packed {
        logic       pad;
        logic [6:0] light;
        logic [6:0] sat;
        logic [8:0] hue;
    } hsl_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    typedef enum int {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 1400;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;   // hue_deg[8:0], sat_pct[15:9], light_pct[22:16], zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // red[7:0], green[15:8], blue[23:16]

    rgb_t     rgb_expected_q[$];
    int       n_sent, n_directed, n_checked, n_mismatch, n_wrapped, n_clamped;
    int       burst_left;
    bit       gaps_on = 1'b0;
    bit       hold_req;
    int       hold_left;
    rx_mode_t rx_mode = RX_STEADY;
    int       rx_mode_left;
    int       rx_tick;

    hsl_to_rgb_converter_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Timeout with %0d results outstanding", rgb_expected_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic hsl_t color(input int unsigned h, input int unsigned s,
                                   input int unsigned l);
        hsl_t c;
        c.pad   = 1'b0;
        c.hue   = h[8:0];
        c.sat   = s[6:0];
        c.light = l[6:0];
        return c;
    endfunction

    function automatic rgb_t hsl_to_rgb(input hsl_t c);
        int unsigned h, s, l, l_off, cn, hm, hd, cu, xu, mu;
        int unsigned comp[3];
        logic [7:0]  ch[3];
        longint      q;
        sector_t     sec;
        rgb_t        res;
        h     = c.hue % HUE_FULL;
        s     = (c.sat > PCT_FULL) ? PCT_FULL : c.sat;
        l     = (c.light > PCT_FULL) ? PCT_FULL : c.light;
        l_off = (2 * l >= PCT_FULL) ? 2 * l - PCT_FULL : PCT_FULL - 2 * l;
        cn    = (PCT_FULL - l_off) * s;
        hm    = h % (2 * SECTOR_DEG);
        hd    = (hm >= SECTOR_DEG) ? hm - SECTOR_DEG : SECTOR_DEG - hm;
        cu    = cn * SECTOR_DEG;
        xu    = cn * (SECTOR_DEG - hd);
        mu    = l * LIGHT_UNIT - cn * HALF_SECTOR;
        sec   = sector_t'(h / SECTOR_DEG);
        case (sec)
            SEC_R_Y: comp = '{cu, xu, 0};
            SEC_Y_G: comp = '{xu, cu, 0};
            SEC_G_C: comp = '{0, cu, xu};
            SEC_C_B: comp = '{0, xu, cu};
            SEC_B_M: comp = '{xu, 0, cu};
            default: comp = '{cu, 0, xu};
        endcase
        for (int i = 0; i < 3; i++) begin
            q     = (longint'(comp[i] + mu) * 255 + DENOM / 2) / DENOM;
            ch[i] = (q > 255) ? 8'd255 : q[7:0];
        end
        res.red   = ch[0];
        res.green = ch[1];
        res.blue  = ch[2];
        return res;
    endfunction

    task automatic send_color(input hsl_t c);
        if (gaps_on && burst_left <= 0) begin
            burst_left = $urandom_range(40, 1);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge aclk);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        rgb_expected_q.push_back(hsl_to_rgb(c));
        n_sent++;
        if (c.hue >= HUE_FULL)
            n_wrapped++;
        if (c.sat > PCT_FULL || c.light > PCT_FULL)
            n_clamped++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (rgb_expected_q.size() != 0);
    endtask

    task automatic test_field_extremes();
        int unsigned pts[11][3] = '{
            '{0, 0, 0}, '{0, 0, 100}, '{0, 100, 50}, '{0, 100, 0}, '{0, 100, 100},
            '{120, 127, 50}, '{240, 100, 127}, '{300, 127, 127}, '{45, 1, 1},
            '{200, 99, 99}, '{90, 64, 64}
        };
        gaps_on = 1'b0;
        foreach (pts[i])
            send_color(color(pts[i][0], pts[i][1], pts[i][2]));
    endtask

    task automatic test_sector_boundaries();
        int unsigned hues[13] = '{0, 59, 60, 61, 120, 180, 240, 300, 359, 360, 419, 420, 511};
        gaps_on = 1'b1;
        foreach (hues[i])
            send_color(color(hues[i], 100, 50));
    endtask

    task automatic test_output_backpressure();
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (40)
            send_color(color($urandom_range(359, 0), $urandom_range(100, 0),
                             $urandom_range(100, 0)));
    endtask

    task automatic test_random_colors();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 100 == 0)
                gaps_on = ($urandom_range(3, 0) != 0);
            if (i == RANDOM_ITEMS / 2)
                wait_drain();
            if ($urandom_range(9, 0) < 8)
                send_color(color($urandom_range(359, 0), $urandom_range(100, 0),
                                 $urandom_range(100, 0)));
            else
                send_color(color($urandom_range(511, 0), $urandom_range(127, 0),
                                 $urandom_range(127, 0)));
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_mode_left <= 0) begin
                rx_mode      = rx_mode_t'($urandom_range(3, 0));
                rx_mode_left = $urandom_range(200, 20);
            end
            rx_mode_left--;
            case (rx_mode)
                RX_STEADY: m_tready <= 1'b1;
                RX_COIN:   m_tready <= $urandom_range(1, 0);
                RX_SPARSE: m_tready <= ($urandom_range(3, 0) == 0);
                default:   m_tready <= (rx_tick % 3 != 2);
            endcase
        end
    end

    always @(posedge aclk) begin
        rgb_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (rgb_expected_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("%0t: unexpected result r=%0d g=%0d b=%0d",
                             $realtime, got.red, got.green, got.blue);
            end else begin
                want = rgb_expected_q.pop_front();
                n_checked++;
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("%0t: item %0d want r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                 $realtime, n_checked, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_field_extremes();
        wait_drain();
        test_sector_boundaries();
        wait_drain();
        n_directed = n_sent;
        test_output_backpressure();
        wait_drain();
        test_random_colors();
        wait_drain();
        repeat (20) @(posedge aclk);
        if (rgb_expected_q.size() != 0) begin
            $display("%0d expected results never arrived", rgb_expected_q.size());
            n_mismatch += rgb_expected_q.size();
        end
        $display("Checked %0d of %0d requests (%0d directed); %0d hue wraps, %0d clamps.",
                 n_checked, n_sent, n_directed, n_wrapped, n_clamped);
        $display("Output held off for %0d cycles once; sender bursts and receiver stalls varied.",
                 HOLD_CYCLES);
        if (n_mismatch == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/hsl2rgb_pkg.sv
rtl/core/hsl2rgb_front.sv
rtl/core/hsl2rgb_mix.sv
rtl/core/hsl2rgb_scale.sv
rtl/core/hsl_to_rgb_converter_unit.sv
test/tb_hsl_to_rgb_converter_unit.sv
